// ----- src/psq_pkg.sv -----
package psq_pkg;

	// Cell indexes cover the largest supported store of 256 words.
	localparam int CELL_IDX_W = 8;

	typedef enum logic [2:0] {
		REQ_PUSH_HEAD = 3'd0,
		REQ_PUSH_TAIL = 3'd1,
		REQ_INSERT    = 3'd2,
		REQ_DELETE    = 3'd3,
		REQ_READ      = 3'd4,
		REQ_CLEAR     = 3'd5
	} req_code_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [CELL_IDX_W-1:0] idx;
	} cell_cmd_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [4:0]         position;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [4:0]         entry_count;
	} rsp_item_t;

endpackage

// ----- src/psq_stream_if.sv -----
interface psq_stream_if import psq_pkg::*; #(
	parameter type payload_t = req_item_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- src/positional_sequence_store.sv -----
// Channel | Modport | Payload    | Meaning
// req     | sink    | req_item_t | one request: req_type, position, value
// rsp     | source  | rsp_item_t | one result: status, read_value, entry_count
//
// Every request is taken when req.valid and req.ready are both high, and its result
// is registered into the output register, so one request per cycle is sustained while rsp takes each result.
// The rate is set by the row of cells: all cells shift together on the same edge.
// A new request is taken while the held result is being taken in the same cycle.
// Reset (arst_n low) empties the store and drops any held result.
// When rsp is stalled with a result held, req is stalled too.
module positional_sequence_store import psq_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	psq_stream_if.sink   req,
	psq_stream_if.source rsp
);
	// Count width holds CAPACITY itself; compares use a width that fits
	// both the count and a 5-bit position plus one.
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CMP_W     = ((CNT_W > 5) ? CNT_W : 5) + 1;
	// Positions reach at most 31, so only the first 31 cells can be read.
	localparam int RD_N      = (CAPACITY < 31) ? CAPACITY : 31;
	localparam int RD_IDX_W  = (RD_N > 1) ? $clog2(RD_N) : 1;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	logic             out_valid_q;
	rsp_item_t        out_q;
	rsp_item_t        rsp_next;
	cell_cmd_t        cmd;
	logic             accept;

	logic signed [DATA_WIDTH-1:0] new_word;
	logic signed [DATA_WIDTH-1:0] cell_words [CAPACITY];
	logic signed [DATA_WIDTH-1:0] rd_words [RD_N];
	logic signed [DATA_WIDTH-1:0] rd_word;

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [4:0]       pos_m1;
	logic             pos_ok_ins;
	logic             pos_ok_rd;
	logic             full;

	// A request is taken whenever the output register is free or being emptied.
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// The size cast keeps the low bits or sign-extends, as DATA_WIDTH asks.
	assign new_word = DATA_WIDTH'(req.payload.value);

	assign pos_x      = CMP_W'(req.payload.position);
	assign cnt_x      = CMP_W'(cnt_q);
	assign pos_m1     = req.payload.position - 5'd1;
	assign pos_ok_ins = (req.payload.position != 5'd0) && (pos_x <= cnt_x + CMP_W'(1));
	assign pos_ok_rd  = (req.payload.position != 5'd0) && (pos_x <= cnt_x);
	assign full       = (cnt_q == CNT_W'(CAPACITY));

	// The row of cells: position p lives in cell p-1. Inserts shift toward the
	// tail through the left neighbor, deletes toward the head through the right.
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic signed [DATA_WIDTH-1:0] left_w;
		logic signed [DATA_WIDTH-1:0] right_w;

		if (j == 0) begin : g_head
			assign left_w = new_word;
		end else begin : g_mid_l
			assign left_w = cell_words[j-1];
		end

		if (j == CAPACITY - 1) begin : g_tail
			assign right_w = cell_words[j];
		end else begin : g_mid_r
			assign right_w = cell_words[j+1];
		end

		psq_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.INDEX     (j)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.new_word  (new_word),
			.left_word (left_w),
			.right_word(right_w),
			.word      (cell_words[j])
		);
	end

	for (genvar j = 0; j < RD_N; j++) begin : g_rd
		assign rd_words[j] = cell_words[j];
	end

	assign rd_word = rd_words[RD_IDX_W'(pos_m1)];

	// Decode the request into the cell command, the next count and the result.
	always_comb begin
		cmd.op               = CELL_HOLD;
		cmd.idx              = '0;
		cnt_next             = cnt_q;
		rsp_next.status      = ST_DONE;
		rsp_next.read_value  = '0;

		case (req.payload.req_type)
			REQ_PUSH_HEAD, REQ_PUSH_TAIL: begin
				if (full) begin
					rsp_next.status = ST_FULL;
				end else begin
					cmd.op   = CELL_INSERT;
					cmd.idx  = (req.payload.req_type == REQ_PUSH_HEAD) ? '0 :
					           CELL_IDX_W'(cnt_q);
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			REQ_INSERT: begin
				if (!pos_ok_ins) begin
					rsp_next.status = ST_BAD_POS;
				end else if (full) begin
					rsp_next.status = ST_FULL;
				end else begin
					cmd.op   = CELL_INSERT;
					cmd.idx  = CELL_IDX_W'(pos_m1);
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			REQ_DELETE: begin
				if (!pos_ok_rd) begin
					rsp_next.status = ST_BAD_POS;
				end else begin
					cmd.op   = CELL_DELETE;
					cmd.idx  = CELL_IDX_W'(pos_m1);
					cnt_next = cnt_q - CNT_W'(1);
				end
			end
			REQ_READ: begin
				if (!pos_ok_rd) begin
					rsp_next.status = ST_BAD_POS;
				end else begin
					rsp_next.read_value = 32'(rd_word);
				end
			end
			REQ_CLEAR: begin
				cnt_next = '0;
			end
			default: begin
				// Unused request codes leave the store as it is.
			end
		endcase

		rsp_next.entry_count = 5'(cnt_next);

		// Nothing moves unless the request is really taken.
		if (!accept) begin
			cmd.op = CELL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= rsp_next;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.payload.req_type == REQ_CLEAR) |=> (cnt_q == '0))
		else $error("clear did not empty the store");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !full && (req.payload.req_type == REQ_PUSH_TAIL)
		|=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("push did not grow the store");

	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.entry_count == 5'(cnt_q)))
		else $error("held result disagrees with the stored count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == ST_FULL) |-> full)
		else $error("full status reported while the store has room");
`endif
endmodule

// ----- src/psq_cell.sv -----
module psq_cell import psq_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  logic                         clk,
	input  cell_cmd_t                    cmd,
	input  logic signed [DATA_WIDTH-1:0] new_word,
	input  logic signed [DATA_WIDTH-1:0] left_word,
	input  logic signed [DATA_WIDTH-1:0] right_word,
	output logic signed [DATA_WIDTH-1:0] word
);
	localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(INDEX);

	logic signed [DATA_WIDTH-1:0] word_q;

	// Each cell picks its next word from its own index and the broadcast command.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (MY_IDX == cmd.idx) begin
					word_q <= new_word;
				end else if (MY_IDX > cmd.idx) begin
					word_q <= left_word;
				end
			end
			CELL_DELETE: begin
				if (MY_IDX >= cmd.idx) begin
					word_q <= right_word;
				end
			end
			default: begin
			end
		endcase
	end

	assign word = word_q;
endmodule
